/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst_n, cond)

`endif

`endif

/* rtl/hkrb_pkg.sv */
package hkrb_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int KEY_SLOTS_DEF   = 6;
    localparam int REPORT_SLOTS    = 6;
    localparam int CODE_W          = 8;
    localparam int IDLE_W          = 8;
    localparam int STATUS_W        = 3;
    localparam int IN_DATA_W       = 16;
    localparam int IN_USER_W       = 2;
    localparam int OUT_DATA_W      = REPORT_SLOTS * CODE_W;
    localparam int OUT_USER_W      = 1 + STATUS_W;

    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_TX_DONE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_CHANGED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOCHANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOFREE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_QUEUE = 2'd1;
    localparam logic [1:0] SRC_SLOTS = 2'd2;

    typedef struct packed {
        logic load_in;
        logic key_step;
        logic read_step;
        logic load_out;
    } hkrb_cmd_t;

    typedef struct packed {
        logic out_free;
        logic q_empty;
        logic q_full;
    } hkrb_stat_t;

endpackage

/* rtl/hid_keyboard_report_builder.sv */
// Six-key-rollover boot keyboard report builder. Each input transfer is a key
// press, key release or transmit-complete event; each produces exactly one
// output transfer with the status of the key action and, when the link is
// active and the endpoint free, the report sent: the oldest queued snapshot
// of the key slots, or the current slots when the queue is empty and the idle
// rate is nonzero. One item is processed at a time in four steps (input
// capture, key update and queue write, queue read, output load), so a new
// item is taken only after the last one is through the output load step; the
// queue read step exists because the snapshot queue memory is read through a
// register. A stalled output holds the item in the output load step. The next
// item is taken while the previous result still waits in the output register.
// The queue needs no clearing after reset: only written entries are read.
module hid_keyboard_report_builder
#(
    parameter int QUEUE_DEPTH = hkrb_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_SLOTS   = hkrb_pkg::KEY_SLOTS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [hkrb_pkg::IDLE_W-1:0]     cfg_wr_data,  // idle_rate
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hkrb_pkg::IN_DATA_W-1:0]  s_tdata,      // key_code, link_active, endpoint_free
    input  logic [hkrb_pkg::IN_USER_W-1:0]  s_tuser,      // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hkrb_pkg::OUT_DATA_W-1:0] m_tdata,      // slot0 .. slot5
    output logic [hkrb_pkg::OUT_USER_W-1:0] m_tuser       // sent, status
);
    import hkrb_pkg::*;

`include "assert_macros.svh"

    hkrb_cmd_t  cmd;
    hkrb_stat_t stat;

    hkrb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hkrb_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_SLOTS   (KEY_SLOTS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    `ASSERT_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `ASSERT_IMPL(a_unsent_zero, clk, rst_n, m_tvalid && !m_tuser[0], m_tdata == '0)
    `ASSERT_IMPL(a_status_range, clk, rst_n, m_tvalid, m_tuser[OUT_USER_W-1:1] <= ST_NOTFOUND)
    `ASSERT_ALWAYS(a_queue_sane, clk, rst_n, !(stat.q_full && stat.q_empty))

endmodule

/* rtl/hkrb_ctrl.sv */
module hkrb_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  hkrb_pkg::hkrb_stat_t stat,
    output hkrb_pkg::hkrb_cmd_t  cmd
);
    import hkrb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_KEY  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_KEY;
                end
            end
            S_KEY:
            begin
                cmd.key_step = 1'b1;
                state_next   = S_READ;
            end
            S_READ:
            begin
                cmd.read_step = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/hkrb_datapath.sv */
module hkrb_datapath
#(
    parameter int QUEUE_DEPTH = hkrb_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_SLOTS   = hkrb_pkg::KEY_SLOTS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [hkrb_pkg::IDLE_W-1:0]     cfg_wr_data,
    input  logic [hkrb_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [hkrb_pkg::IN_USER_W-1:0]  s_tuser,
    input  hkrb_pkg::hkrb_cmd_t             cmd,
    output hkrb_pkg::hkrb_stat_t            stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hkrb_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [hkrb_pkg::OUT_USER_W-1:0] m_tuser
);
    import hkrb_pkg::*;

    localparam int QW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int SW     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int SNAP_W = KEY_SLOTS * CODE_W;

    logic [1:0]        op_reg;
    logic [CODE_W-1:0] code_reg;
    logic              link_reg;
    logic              epf_reg;
    logic [IDLE_W-1:0] idle_rate_reg;

    logic [CODE_W-1:0] slots_reg  [KEY_SLOTS];
    logic [CODE_W-1:0] slots_next [KEY_SLOTS];

    logic [QW-1:0] head_reg;
    logic [QW-1:0] head_next;
    logic [QW-1:0] tail_reg;
    logic [QW-1:0] tail_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic [SNAP_W-1:0] mem [QUEUE_DEPTH];
    logic [SNAP_W-1:0] rd_data_reg;
    logic [SNAP_W-1:0] snap;

    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [1:0]          src_reg;
    logic [1:0]          src_next;

    logic              m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_USER_W-1:0] m_user_reg;
    logic [OUT_DATA_W-1:0] report;

    logic          any_hit;
    logic          any_empty;
    logic [SW-1:0] hit_idx;
    logic [SW-1:0] empty_idx;
    logic          change;
    logic          enq;
    logic          deq;
    logic          q_full;
    logic          q_empty;

    assign q_full  = (count_reg == CW'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);

    // lowest matching and lowest empty slot
    always_comb
    begin
        any_hit   = 1'b0;
        any_empty = 1'b0;
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = KEY_SLOTS - 1; i >= 0; i--)
        begin
            if (slots_reg[i] == code_reg)
            begin
                any_hit = 1'b1;
                hit_idx = SW'(i);
            end
            if (slots_reg[i] == '0)
            begin
                any_empty = 1'b1;
                empty_idx = SW'(i);
            end
        end
    end

    always_comb
    begin
        slots_next  = slots_reg;
        status_next = status_reg;
        change      = 1'b0;
        if (cmd.key_step)
        begin
            status_next = ST_NOCHANGE;
            case (op_reg)
                OP_PRESS:
                begin
                    if (code_reg != '0 && !any_hit)
                    begin
                        if (!any_empty)
                            status_next = ST_NOFREE;
                        else
                        begin
                            slots_next[empty_idx] = code_reg;
                            change = 1'b1;
                        end
                    end
                end
                OP_RELEASE:
                begin
                    if (code_reg != '0)
                    begin
                        if (any_hit)
                        begin
                            slots_next[hit_idx] = '0;
                            change = 1'b1;
                        end
                        else
                            status_next = ST_NOTFOUND;
                    end
                end
                default:
                begin
                    status_next = ST_NOCHANGE;
                end
            endcase
            if (change)
                status_next = q_full ? ST_DROPPED : ST_CHANGED;
        end
    end

    assign enq = change && !q_full;

    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
            snap[i*CODE_W +: CODE_W] = slots_next[i];
    end

    // transmit decision after the key action
    always_comb
    begin
        src_next = src_reg;
        deq      = 1'b0;
        if (cmd.read_step)
        begin
            src_next = SRC_NONE;
            if (link_reg && epf_reg)
            begin
                if (!q_empty)
                begin
                    src_next = SRC_QUEUE;
                    deq      = 1'b1;
                end
                else if (idle_rate_reg != '0)
                    src_next = SRC_SLOTS;
            end
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (enq)
        begin
            tail_next  = (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (deq)
        begin
            head_next  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
            mem[tail_reg] <= snap;
    end

    always_ff @(posedge clk)
    begin
        if (deq)
            rd_data_reg <= mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= s_tuser[1:0];
            code_reg <= s_tdata[CODE_W-1:0];
            link_reg <= s_tdata[CODE_W];
            epf_reg  <= s_tdata[CODE_W+1];
        end
        status_reg <= status_next;
        src_reg    <= src_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_rate_reg <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            for (int i = 0; i < KEY_SLOTS; i++)
                slots_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                idle_rate_reg <= cfg_wr_data;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            slots_reg <= slots_next;
        end
    end

    genvar j;
    generate
        for (j = 0; j < REPORT_SLOTS; j++)
        begin : g_report
            if (j < KEY_SLOTS)
            begin : g_live
                assign report[j*CODE_W +: CODE_W] =
                    (src_reg == SRC_QUEUE) ? rd_data_reg[j*CODE_W +: CODE_W] :
                    (src_reg == SRC_SLOTS) ? slots_reg[j] : '0;
            end
            else
            begin : g_pad
                assign report[j*CODE_W +: CODE_W] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_data_reg <= report;
            m_user_reg <= {status_reg, (src_reg != SRC_NONE)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.load_out)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = m_data_reg;
    assign m_tuser       = m_user_reg;
    assign stat.out_free = !m_valid_reg || m_tready;
    assign stat.q_empty  = q_empty;
    assign stat.q_full   = q_full;

endmodule
